// File: rtl/b2z_pkg.sv
// ----------------------------------------------------------------------------
// b2z_pkg: shared types and constants of the bracket token translator
// Token classes, status codes, register indexes, opcodes and the result
// bundle that travels from the execute stage to the output buffer.
// ----------------------------------------------------------------------------
package b2z_pkg;

  // Widths fixed by the result fields.
  localparam int ADDR_W = 12;
  localparam int SIZE_W = 13;
  localparam int MAX_BEATS = 4;

  // Token classes, in decode priority order.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ADD,
    CLS_SUB,
    CLS_RIGHT,
    CLS_LEFT,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_PRINT
  } cls_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ALT_ADD   = 3'd0;
  localparam logic [2:0] REG_ALT_SUB   = 3'd1;
  localparam logic [2:0] REG_ALT_RIGHT = 3'd2;
  localparam logic [2:0] REG_ALT_LEFT  = 3'd3;
  localparam logic [2:0] REG_ALT_OPEN  = 3'd4;
  localparam logic [2:0] REG_ALT_CLOSE = 3'd5;
  localparam logic [2:0] REG_ALT_PRINT = 3'd6;
  localparam logic [2:0] REG_START     = 3'd7;

  // Register reset values.
  localparam logic [7:0] ALT_ADD_RST   = 8'd112;
  localparam logic [7:0] ALT_SUB_RST   = 8'd113;
  localparam logic [7:0] ALT_RIGHT_RST = 8'd108;
  localparam logic [7:0] ALT_LEFT_RST  = 8'd107;
  localparam logic [7:0] ALT_OPEN_RST  = 8'd6;
  localparam logic [7:0] ALT_CLOSE_RST = 8'd7;
  localparam logic [7:0] ALT_PRINT_RST = 8'd58;
  localparam logic [7:0] START_RST     = 8'd5;

  // ASCII source characters.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Z80 opcodes.
  localparam logic [7:0] OP_INC_AT  = 8'h34;
  localparam logic [7:0] OP_DEC_AT  = 8'h35;
  localparam logic [7:0] OP_INC_PTR = 8'h23;
  localparam logic [7:0] OP_DEC_PTR = 8'h2B;
  localparam logic [7:0] OP_LOAD_A  = 8'h7E;
  localparam logic [7:0] OP_OR_A    = 8'hB7;
  localparam logic [7:0] OP_JR_Z    = 8'h28;
  localparam logic [7:0] OP_JR      = 8'h18;
  localparam logic [7:0] OP_BCALL   = 8'hEF;
  localparam logic [7:0] OP_PUTC_LO = 8'h04;
  localparam logic [7:0] OP_PUTC_HI = 8'h45;
  localparam logic [7:0] OP_RET     = 8'hC9;

  // Alternate token codes.
  typedef struct packed {
    logic [7:0] add_c;
    logic [7:0] sub_c;
    logic [7:0] right_c;
    logic [7:0] left_c;
    logic [7:0] open_c;
    logic [7:0] close_c;
    logic [7:0] print_c;
  } alt_codes_t;

  // Bracket stack commands.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_cmd_t;

  // All results of one item; cnt of zero means no result.
  typedef struct packed {
    logic [2:0]                            cnt;
    logic [MAX_BEATS-1:0][ADDR_W-1:0]      addr;
    logic [MAX_BEATS-1:0][7:0]             data;
    status_t                               status;
    logic [SIZE_W-1:0]                     size;
  } bundle_t;

endpackage

// File: rtl/b2z_decode.sv
// ----------------------------------------------------------------------------
// b2z_decode: token classifier
// Maps a token byte to its class, taking the ASCII character or the
// programmable alternate code, with plus first and dot last in priority.
// ----------------------------------------------------------------------------
module b2z_decode
  import b2z_pkg::*;
(
  input  logic [7:0] token,
  input  alt_codes_t alt,
  output cls_t       cls
);

  // Priority compare against both codes of each class.
  always_comb begin
    if (token == CH_PLUS || token == alt.add_c) begin
      cls = CLS_ADD;
    end else if (token == CH_MINUS || token == alt.sub_c) begin
      cls = CLS_SUB;
    end else if (token == CH_GT || token == alt.right_c) begin
      cls = CLS_RIGHT;
    end else if (token == CH_LT || token == alt.left_c) begin
      cls = CLS_LEFT;
    end else if (token == CH_OPEN || token == alt.open_c) begin
      cls = CLS_OPEN;
    end else if (token == CH_CLOSE || token == alt.close_c) begin
      cls = CLS_CLOSE;
    end else if (token == CH_DOT || token == alt.print_c) begin
      cls = CLS_PRINT;
    end else begin
      cls = CLS_NONE;
    end
  end

endmodule

// File: rtl/b2z_stack.sv
// ----------------------------------------------------------------------------
// b2z_stack: bracket address stack
// Entries live in a memory with a registered read port. The top two entries
// are also held in registers, and the entry below them is prefetched every
// cycle, so a push or a pop can follow in the very next cycle.
// ----------------------------------------------------------------------------
module b2z_stack
  import b2z_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int DW    = 13,
  localparam int TW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_cmd_t      cmd,
  input  logic [DW-1:0] din,
  output logic [TW-1:0] top,
  output logic [DW-1:0] tos
);

  logic [DW-1:0] mem [DEPTH];
  logic [TW-1:0] top_r, top_nxt;
  logic [TW-1:0] rd_ptr;
  logic [DW-1:0] tos_r, nos_r, rd_r;

  // Entry count update; clear wins over push and pop.
  always_comb begin
    top_nxt = top_r;
    if (cmd.clear) begin
      top_nxt = '0;
    end else if (cmd.push) begin
      top_nxt = top_r + TW'(1);
    end else if (cmd.pop) begin
      top_nxt = top_r - TW'(1);
    end
  end

  // The third entry from the new top is read for the next pop.
  assign rd_ptr = top_nxt - TW'(3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

  // Memory write on push, registered prefetch read.
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      mem[top_r[IW-1:0]] <= din;
    end
    rd_r <= mem[rd_ptr[IW-1:0]];
  end

  // Cached top and next entries.
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      tos_r <= din;
      nos_r <= tos_r;
    end else if (cmd.pop && !cmd.clear) begin
      tos_r <= nos_r;
      nos_r <= rd_r;
    end
  end

  assign top = top_r;
  assign tos = tos_r;

endmodule

// File: rtl/b2z_exec.sv
// ----------------------------------------------------------------------------
// b2z_exec: execute stage of the translator
// Holds the write pointer and the error state, checks room, stack and jump
// range for the registered item and builds all of its results at once.
// ----------------------------------------------------------------------------
module b2z_exec
  import b2z_pkg::*;
#(
  parameter int PROG_BYTES  = 4096,
  parameter int STACK_DEPTH = 64,
  localparam int PW = $clog2(PROG_BYTES + 1),
  localparam int TW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic          mode,
  input  cls_t          cls,
  input  logic [7:0]    start_offset,
  input  logic          cfg_restart,
  input  logic [7:0]    cfg_offset,
  input  logic [TW-1:0] stk_top,
  input  logic [PW-1:0] stk_tos,
  output stk_cmd_t      stk_cmd,
  output logic [PW-1:0] push_data,
  output bundle_t       bundle
);

  localparam logic [PW:0] LIMIT = (PW + 1)'(PROG_BYTES);

  logic [PW-1:0]     wp_r, wp_nxt;
  logic              err_r, err_nxt;
  status_t           ferr_r, ferr_nxt;
  logic [PW:0]       wp_ext;
  logic [ADDR_W-1:0] wp_a;
  logic              fit1, fit2, fit4;
  logic [PW-1:0]     jmp_dist;
  logic [7:0]        d8;
  logic              range_bad, stk_empty, stk_full;
  logic              fail;
  status_t           fail_code;
  stk_cmd_t          cmd;

  // Room, stack and jump range checks.
  assign wp_ext    = {1'b0, wp_r};
  assign wp_a      = ADDR_W'(wp_r);
  assign fit1      = (wp_ext + (PW + 1)'(1)) <= LIMIT;
  assign fit2      = (wp_ext + (PW + 1)'(2)) <= LIMIT;
  assign fit4      = (wp_ext + (PW + 1)'(4)) <= LIMIT;
  assign jmp_dist  = wp_r - stk_tos;
  assign d8        = jmp_dist[7:0];
  assign range_bad = ({1'b0, jmp_dist} + (PW + 1)'(2)) > (PW + 1)'(128);
  assign stk_empty = (stk_top == '0);
  assign stk_full  = (stk_top >= TW'(STACK_DEPTH));

  // Result bundle and next state for the current item.
  always_comb begin
    bundle    = '0;
    wp_nxt    = wp_r;
    err_nxt   = err_r;
    ferr_nxt  = ferr_r;
    cmd       = '0;
    fail      = 1'b0;
    fail_code = ST_OK;
    for (int i = 0; i < MAX_BEATS; i++) begin
      bundle.addr[i] = wp_a + ADDR_W'(i);
    end
    if (mode) begin
      // Finish: return byte, the pending error or a full status, then restart.
      bundle.cnt = 3'd1;
      if (err_r) begin
        bundle.status = ferr_r;
      end else if (!fit1) begin
        bundle.status = ST_FULL;
      end else begin
        bundle.data[0] = OP_RET;
        bundle.size    = SIZE_W'(wp_ext + (PW + 1)'(1));
      end
      wp_nxt    = PW'(start_offset);
      err_nxt   = 1'b0;
      ferr_nxt  = ST_OK;
      cmd.clear = 1'b1;
    end else if (!err_r) begin
      case (cls)
        CLS_ADD, CLS_SUB, CLS_RIGHT, CLS_LEFT: begin
          if (!fit1) begin
            fail      = 1'b1;
            fail_code = ST_FULL;
          end else begin
            bundle.cnt = 3'd1;
            case (cls)
              CLS_ADD:   bundle.data[0] = OP_INC_AT;
              CLS_SUB:   bundle.data[0] = OP_DEC_AT;
              CLS_RIGHT: bundle.data[0] = OP_INC_PTR;
              default:   bundle.data[0] = OP_DEC_PTR;
            endcase
            wp_nxt = wp_r + PW'(1);
          end
        end
        CLS_OPEN: begin
          if (stk_full) begin
            fail      = 1'b1;
            fail_code = ST_OVERFLOW;
          end else if (!fit4) begin
            fail      = 1'b1;
            fail_code = ST_FULL;
          end else begin
            bundle.cnt     = 3'd4;
            bundle.data[0] = OP_LOAD_A;
            bundle.data[1] = OP_OR_A;
            bundle.data[2] = OP_JR_Z;
            bundle.data[3] = 8'h00;
            cmd.push       = 1'b1;
            wp_nxt         = wp_r + PW'(4);
          end
        end
        CLS_CLOSE: begin
          if (stk_empty) begin
            fail      = 1'b1;
            fail_code = ST_UNMATCHED;
          end else if (!fit2) begin
            fail      = 1'b1;
            fail_code = ST_FULL;
          end else if (range_bad) begin
            fail      = 1'b1;
            fail_code = ST_RANGE;
          end else begin
            // Backward jump, then patch of the forward offset.
            bundle.cnt     = 3'd3;
            bundle.data[0] = OP_JR;
            bundle.data[1] = 8'd0 - (d8 + 8'd2);
            bundle.addr[2] = ADDR_W'(stk_tos) + ADDR_W'(3);
            bundle.data[2] = d8 - 8'd2;
            cmd.pop        = 1'b1;
            wp_nxt         = wp_r + PW'(2);
          end
        end
        CLS_PRINT: begin
          if (!fit4) begin
            fail      = 1'b1;
            fail_code = ST_FULL;
          end else begin
            bundle.cnt     = 3'd4;
            bundle.data[0] = OP_LOAD_A;
            bundle.data[1] = OP_BCALL;
            bundle.data[2] = OP_PUTC_LO;
            bundle.data[3] = OP_PUTC_HI;
            wp_nxt         = wp_r + PW'(4);
          end
        end
        default: begin
        end
      endcase
      // An error gives one non-write result and locks out tokens.
      if (fail) begin
        bundle.cnt     = 3'd1;
        bundle.addr[0] = wp_a;
        bundle.data    = '0;
        bundle.status  = fail_code;
        err_nxt        = 1'b1;
        ferr_nxt       = fail_code;
      end
    end
  end

  // Stack commands only when an item executes; a start write clears.
  always_comb begin
    stk_cmd       = fire ? cmd : '0;
    stk_cmd.clear = (fire && cmd.clear) || cfg_restart;
  end

  assign push_data = wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= PW'(START_RST);
      err_r  <= 1'b0;
      ferr_r <= ST_OK;
    end else if (cfg_restart) begin
      wp_r   <= PW'(cfg_offset);
      err_r  <= 1'b0;
      ferr_r <= ST_OK;
    end else if (fire) begin
      wp_r   <= wp_nxt;
      err_r  <= err_nxt;
      ferr_r <= ferr_nxt;
    end
  end

endmodule

// File: rtl/b2z_outbuf.sv
// ----------------------------------------------------------------------------
// b2z_outbuf: result serializer
// Holds one item's results, handing them out one per cycle while out_stall
// is low; it takes the next bundle in the cycle its last result leaves.
// ----------------------------------------------------------------------------
module b2z_outbuf
  import b2z_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bundle_t           bnd_in,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_address,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic [2:0]        out_status,
  output logic [SIZE_W-1:0] out_program_size
);

  logic    vld_r, vld_nxt;
  logic [1:0] k_r, k_nxt;
  bundle_t bnd_r;
  logic    leave, is_last, take;

  assign leave   = vld_r && !out_stall;
  assign is_last = (k_r == 2'(bnd_r.cnt - 3'd1));
  assign free    = !vld_r || (leave && is_last);
  assign take    = load && (bnd_in.cnt != 3'd0);

  // Beat counter and occupancy.
  always_comb begin
    vld_nxt = vld_r;
    k_nxt   = k_r;
    if (leave) begin
      if (is_last) begin
        vld_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end
    if (take) begin
      vld_nxt = 1'b1;
      k_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= '0;
    end else begin
      vld_r <= vld_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bnd_r <= bnd_in;
    end
  end

  // Current beat.
  assign out_valid        = vld_r;
  assign out_address      = bnd_r.addr[k_r];
  assign out_byte         = bnd_r.data[k_r];
  assign out_last         = is_last;
  assign out_status       = bnd_r.status;
  assign out_program_size = bnd_r.size;

endmodule

// File: rtl/bracket_token_to_z80_translator.sv
// ----------------------------------------------------------------------------
// bracket_token_to_z80_translator: bracket token to Z80 code translator
// Turns source tokens into (address, byte) writes of Z80 machine code,
// matching brackets on an address stack and patching forward jumps.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    in_mode, in_token
//   out      out_valid / out_stall  out_address, out_byte, out_last,
//                                   out_status, out_program_size
//   cfg      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// An item is registered when accepted and executed once the output buffer is
// free; its results load into that buffer, which sends one result per cycle
// while out_stall is low. An item causes 1 to 4 results, or none; the buffer
// takes the next item's results in the cycle its last result leaves.
// The first result is driven from the output buffer's registers.
// Reset (rst_n low at a clock edge) loads the register defaults, empties
// the stack and sets the write pointer to the start offset.
// out_stall holds the current result; the input keeps one item waiting and
// raises in_stall only while that item cannot move into the output buffer.
// ----------------------------------------------------------------------------
module bracket_token_to_z80_translator
  import b2z_pkg::*;
#(
  parameter int PROG_BYTES  = 4096,
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // Source items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [7:0]        in_token,
  // Code writes
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_address,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic [2:0]        out_status,
  output logic [SIZE_W-1:0] out_program_size,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PW = $clog2(PROG_BYTES + 1);
  localparam int TW = $clog2(STACK_DEPTH + 1);

  alt_codes_t    alt_r;
  logic [7:0]    start_r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;
  logic          in_vld_r;
  logic          mode_r;
  logic [7:0]    token_r;
  logic          fire, ob_free;
  cls_t          cls;
  stk_cmd_t      stk_cmd;
  logic [PW-1:0] push_data, stk_tos;
  logic [TW-1:0] stk_top;
  bundle_t       bundle;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_r.add_c   <= ALT_ADD_RST;
      alt_r.sub_c   <= ALT_SUB_RST;
      alt_r.right_c <= ALT_RIGHT_RST;
      alt_r.left_c  <= ALT_LEFT_RST;
      alt_r.open_c  <= ALT_OPEN_RST;
      alt_r.close_c <= ALT_CLOSE_RST;
      alt_r.print_c <= ALT_PRINT_RST;
      start_r       <= START_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ALT_ADD:   alt_r.add_c   <= pwdata[7:0];
        REG_ALT_SUB:   alt_r.sub_c   <= pwdata[7:0];
        REG_ALT_RIGHT: alt_r.right_c <= pwdata[7:0];
        REG_ALT_LEFT:  alt_r.left_c  <= pwdata[7:0];
        REG_ALT_OPEN:  alt_r.open_c  <= pwdata[7:0];
        REG_ALT_CLOSE: alt_r.close_c <= pwdata[7:0];
        REG_ALT_PRINT: alt_r.print_c <= pwdata[7:0];
        REG_START:     start_r       <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      REG_ALT_ADD:   prdata = {24'd0, alt_r.add_c};
      REG_ALT_SUB:   prdata = {24'd0, alt_r.sub_c};
      REG_ALT_RIGHT: prdata = {24'd0, alt_r.right_c};
      REG_ALT_LEFT:  prdata = {24'd0, alt_r.left_c};
      REG_ALT_OPEN:  prdata = {24'd0, alt_r.open_c};
      REG_ALT_CLOSE: prdata = {24'd0, alt_r.close_c};
      REG_ALT_PRINT: prdata = {24'd0, alt_r.print_c};
      REG_START:     prdata = {24'd0, start_r};
      default:       prdata = '0;
    endcase
  end

  // Input register; the item executes when the output buffer can take it.
  assign fire     = in_vld_r && ob_free;
  assign in_stall = in_vld_r && !ob_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r  <= in_mode;
      token_r <= in_token;
    end
  end

  b2z_decode u_decode (
    .token (token_r),
    .alt   (alt_r),
    .cls   (cls)
  );

  b2z_stack #(
    .DEPTH (STACK_DEPTH),
    .DW    (PW)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .din   (push_data),
    .top   (stk_top),
    .tos   (stk_tos)
  );

  b2z_exec #(
    .PROG_BYTES  (PROG_BYTES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .mode         (mode_r),
    .cls          (cls),
    .start_offset (start_r),
    .cfg_restart  (cfg_wr && (cfg_idx == REG_START)),
    .cfg_offset   (pwdata[7:0]),
    .stk_top      (stk_top),
    .stk_tos      (stk_tos),
    .stk_cmd      (stk_cmd),
    .push_data    (push_data),
    .bundle       (bundle)
  );

  b2z_outbuf u_outbuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (fire),
    .bnd_in           (bundle),
    .free             (ob_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_address      (out_address),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_program_size (out_program_size)
  );

  // An error result is always the only result of its item.
  a_err_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("error result not marked last");

  // A program size comes only with the return byte of a finish.
  a_size_ret : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_program_size != '0)) |-> (out_last && (out_byte == OP_RET)))
    else $error("program size outside finish result");

  // The bracket stack never holds more than its depth.
  a_stk_depth : assert property (@(posedge clk) disable iff (!rst_n)
    stk_top <= TW'(STACK_DEPTH))
    else $error("bracket stack overfilled");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bracket token to Z80 code translator
// Drives source tokens and finish items with random sender gaps and receiver
// stalls, programs the alternate codes and start offset over an APB-style
// port, and checks every code write against a cycle-free model of the
// translator that tracks write pointer, bracket stack and sticky errors.
// ----------------------------------------------------------------------------
import b2z_pkg::*;

// One code write as it leaves the block.
typedef struct {
  logic [ADDR_W-1:0] addr;
  logic [7:0]        data;
  logic              last;
  status_t           status;
  logic [SIZE_W-1:0] size;
} code_write_t;

// Translator model plus the queue of code writes still to arrive.
class code_scoreboard #(int STORE_BYTES = 4096, int STACK_SLOTS = 64);
  alt_codes_t  codes;
  logic [7:0]  start_addr;
  int unsigned wp;
  int unsigned open_stack [STACK_SLOTS];
  int unsigned top;
  bit          err_seen;
  status_t     first_err;
  code_write_t expected_q [$];
  int          mismatches;
  int          writes_checked;

  function new();
    codes = '{add_c: ALT_ADD_RST, sub_c: ALT_SUB_RST, right_c: ALT_RIGHT_RST,
              left_c: ALT_LEFT_RST, open_c: ALT_OPEN_RST, close_c: ALT_CLOSE_RST,
              print_c: ALT_PRINT_RST};
    start_addr = START_RST;
    mismatches = 0;
    writes_checked = 0;
    restart();
  endfunction

  // A finish or a new start offset begins a fresh program.
  function void restart();
    wp = start_addr;
    top = 0;
    err_seen = 1'b0;
    first_err = ST_OK;
    foreach (open_stack[i]) open_stack[i] = 0;
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("%0t MISMATCH %s", $realtime, msg);
  endtask

  function logic [7:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_ALT_ADD:   return codes.add_c;
      REG_ALT_SUB:   return codes.sub_c;
      REG_ALT_RIGHT: return codes.right_c;
      REG_ALT_LEFT:  return codes.left_c;
      REG_ALT_OPEN:  return codes.open_c;
      REG_ALT_CLOSE: return codes.close_c;
      REG_ALT_PRINT: return codes.print_c;
      default:       return start_addr;
    endcase
  endfunction

  function void write_reg(logic [2:0] idx, logic [7:0] v);
    case (idx)
      REG_ALT_ADD:   codes.add_c = v;
      REG_ALT_SUB:   codes.sub_c = v;
      REG_ALT_RIGHT: codes.right_c = v;
      REG_ALT_LEFT:  codes.left_c = v;
      REG_ALT_OPEN:  codes.open_c = v;
      REG_ALT_CLOSE: codes.close_c = v;
      REG_ALT_PRINT: codes.print_c = v;
      default: begin
        start_addr = v;
        restart();
      end
    endcase
  endfunction

  // The first class that matches wins, ASCII or alternate alike.
  function cls_t classify(logic [7:0] t);
    if (t == CH_PLUS  || t == codes.add_c)   return CLS_ADD;
    if (t == CH_MINUS || t == codes.sub_c)   return CLS_SUB;
    if (t == CH_GT    || t == codes.right_c) return CLS_RIGHT;
    if (t == CH_LT    || t == codes.left_c)  return CLS_LEFT;
    if (t == CH_OPEN  || t == codes.open_c)  return CLS_OPEN;
    if (t == CH_CLOSE || t == codes.close_c) return CLS_CLOSE;
    if (t == CH_DOT   || t == codes.print_c) return CLS_PRINT;
    return CLS_NONE;
  endfunction

  function logic [7:0] char_of(cls_t c, bit alternate);
    case (c)
      CLS_ADD:   return alternate ? codes.add_c   : CH_PLUS;
      CLS_SUB:   return alternate ? codes.sub_c   : CH_MINUS;
      CLS_RIGHT: return alternate ? codes.right_c : CH_GT;
      CLS_LEFT:  return alternate ? codes.left_c  : CH_LT;
      CLS_OPEN:  return alternate ? codes.open_c  : CH_OPEN;
      CLS_CLOSE: return alternate ? codes.close_c : CH_CLOSE;
      CLS_PRINT: return alternate ? codes.print_c : CH_DOT;
      default:   return 8'h00;
    endcase
  endfunction

  function bit is_ignored(bit mode, logic [7:0] t);
    return !mode && (err_seen || classify(t) == CLS_NONE);
  endfunction

  function void expect_write(int unsigned a, logic [7:0] d, bit l, status_t s,
                             int unsigned sz);
    code_write_t w;
    w.addr = a[ADDR_W-1:0];
    w.data = d;
    w.last = l;
    w.status = s;
    w.size = sz[SIZE_W-1:0];
    expected_q.push_back(w);
  endfunction

  // An error gives one marker result at the write pointer and sticks.
  function void flag_error(status_t s);
    expect_write(wp, 8'h00, 1'b1, s, 0);
    err_seen = 1'b1;
    first_err = s;
  endfunction

  function void emit_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                           logic [7:0] b3, int n);
    logic [7:0] seq [4];
    seq[0] = b0;
    seq[1] = b1;
    seq[2] = b2;
    seq[3] = b3;
    if (wp + n > STORE_BYTES) begin
      flag_error(ST_FULL);
      return;
    end
    for (int k = 0; k < n; k++) expect_write(wp + k, seq[k], k == n - 1, ST_OK, 0);
    wp += n;
  endfunction

  // Works out the code writes that one accepted item causes.
  function void note_item(bit mode, logic [7:0] t);
    status_t     code;
    int unsigned open_at, jmp_dist, back, fwd;
    if (mode) begin
      if (err_seen) code = first_err;
      else if (wp + 1 > STORE_BYTES) code = ST_FULL;
      else code = ST_OK;
      if (code != ST_OK) expect_write(wp, 8'h00, 1'b1, code, 0);
      else expect_write(wp, OP_RET, 1'b1, ST_OK, wp + 1);
      restart();
      return;
    end
    if (err_seen) return;
    case (classify(t))
      CLS_ADD:   emit_bytes(OP_INC_AT, 8'h00, 8'h00, 8'h00, 1);
      CLS_SUB:   emit_bytes(OP_DEC_AT, 8'h00, 8'h00, 8'h00, 1);
      CLS_RIGHT: emit_bytes(OP_INC_PTR, 8'h00, 8'h00, 8'h00, 1);
      CLS_LEFT:  emit_bytes(OP_DEC_PTR, 8'h00, 8'h00, 8'h00, 1);
      CLS_PRINT: emit_bytes(OP_LOAD_A, OP_BCALL, OP_PUTC_LO, OP_PUTC_HI, 4);
      CLS_OPEN: begin
        if (top >= STACK_SLOTS) begin
          flag_error(ST_OVERFLOW);
        end else begin
          open_at = wp;
          emit_bytes(OP_LOAD_A, OP_OR_A, OP_JR_Z, 8'h00, 4);
          if (!err_seen) begin
            open_stack[top] = open_at;
            top++;
          end
        end
      end
      CLS_CLOSE: begin
        if (top == 0) begin
          flag_error(ST_UNMATCHED);
        end else if (wp + 2 > STORE_BYTES) begin
          flag_error(ST_FULL);
        end else begin
          open_at = open_stack[top - 1];
          jmp_dist = wp - open_at;
          if (jmp_dist + 2 > 128) begin
            flag_error(ST_RANGE);
          end else begin
            // Backward jump to the opening load, then patch the forward jump.
            top--;
            back = 0 - (jmp_dist + 2);
            fwd = jmp_dist - 2;
            expect_write(wp, OP_JR, 1'b0, ST_OK, 0);
            expect_write(wp + 1, back[7:0], 1'b0, ST_OK, 0);
            expect_write(open_at + 3, fwd[7:0], 1'b1, ST_OK, 0);
            wp += 2;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task check_result(logic [ADDR_W-1:0] a, logic [7:0] d, logic l, logic [2:0] s,
                    logic [SIZE_W-1:0] sz);
    code_write_t w;
    writes_checked++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("write %0d unexpected: addr %h byte %h last %b status %0d",
                                writes_checked, a, d, l, s));
      return;
    end
    w = expected_q.pop_front();
    if (a !== w.addr || d !== w.data || l !== w.last || s !== w.status || sz !== w.size)
      report_mismatch($sformatf(
        "write %0d: got %h/%h/%b/%0d/%0d want %h/%h/%b/%0d/%0d (addr/byte/last/status/size)",
        writes_checked, a, d, l, s, sz, w.addr, w.data, w.last, w.status, w.size));
  endtask
endclass

module testbench;
  localparam int PROG_BYTES    = 4096;
  localparam int STACK_DEPTH   = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 4_000_000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_mode;
  logic [7:0]        in_token;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] out_address;
  logic [7:0]        out_byte;
  logic              out_last;
  logic [2:0]        out_status;
  logic [SIZE_W-1:0] out_program_size;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int tx_idle_pct;
  int rx_idle_pct;
  int burst_req;
  int burst_seen;
  int hold_left;
  int items_sent;

  code_scoreboard #(PROG_BYTES, STACK_DEPTH) sb;

  bracket_token_to_z80_translator #(
    .PROG_BYTES (PROG_BYTES),
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_token        (in_token),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_address     (out_address),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_status      (out_status),
    .out_program_size(out_program_size),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_token = 8'h00;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    burst_req = 0;
    burst_seen = 0;
    hold_left = 0;
    items_sent = 0;
  end

  always #1 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (burst_seen != burst_req) begin
      burst_seen = burst_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Every code write taken by the receiver is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_address, out_byte, out_last, out_status, out_program_size);
  end

  // Offers one item, holds it until accepted, then updates the model.
  task automatic send_token(bit mode, logic [7:0] tok);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_token <= tok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!sb.is_ignored(mode, tok)) items_sent++;
    sb.note_item(mode, tok);
  endtask

  // Picks a token that decodes to the class under the current codes, if either does.
  function automatic logic [7:0] token_for(cls_t c);
    logic [7:0] first;
    logic [7:0] second;
    bit         pick;
    pick = $urandom_range(1);
    first = sb.char_of(c, pick);
    second = sb.char_of(c, !pick);
    if (sb.classify(first) == c) return first;
    if (sb.classify(second) == c) return second;
    return first;
  endfunction

  task automatic send_class(cls_t c);
    send_token(1'b0, token_for(c));
  endtask

  task automatic send_finish();
    send_token(1'b1, 8'($urandom_range(255)));
  endtask

  // Sender pause: wait for every outstanding write, then let the block settle.
  task automatic wait_drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (sb.expected_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d expected writes never arrived",
                                   sb.expected_q.size()));
      sb.expected_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register read with the value checked against the model.
  task automatic cfg_read(logic [2:0] idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== {24'h0, sb.reg_value(idx)})
      sb.report_mismatch($sformatf("register %0d reads %h, want %h", idx, got,
                                   sb.reg_value(idx)));
  endtask

  // Register write followed directly by a read-back.
  task automatic cfg_write(logic [2:0] idx, logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_read(idx);
  endtask

  task automatic apply_setting(int which);
    alt_codes_t c;
    logic [7:0] st;
    case (which)
      0: begin
        c = '0;
        st = 8'h00;
      end
      1: begin
        c = '1;
        st = 8'hFF;
      end
      2: begin
        // Alternate codes shadow ASCII characters so that priority decides.
        c = '{add_c: CH_MINUS, sub_c: CH_GT, right_c: CH_LT, left_c: CH_OPEN,
              open_c: CH_CLOSE, close_c: CH_DOT, print_c: CH_PLUS};
        st = 8'($urandom_range(255));
      end
      3: begin
        c = alt_codes_t'({$urandom, $urandom});
        st = 8'($urandom_range(255));
      end
      default: begin
        c = '{add_c: ALT_ADD_RST, sub_c: ALT_SUB_RST, right_c: ALT_RIGHT_RST,
              left_c: ALT_LEFT_RST, open_c: ALT_OPEN_RST, close_c: ALT_CLOSE_RST,
              print_c: ALT_PRINT_RST};
        st = START_RST;
      end
    endcase
    cfg_write(REG_ALT_ADD, c.add_c);
    cfg_write(REG_ALT_SUB, c.sub_c);
    cfg_write(REG_ALT_RIGHT, c.right_c);
    cfg_write(REG_ALT_LEFT, c.left_c);
    cfg_write(REG_ALT_OPEN, c.open_c);
    cfg_write(REG_ALT_CLOSE, c.close_c);
    cfg_write(REG_ALT_PRINT, c.print_c);
    cfg_write(REG_START, st);
  endtask

  // A loop whose body puts the backward jump close to the edge of its range.
  task automatic long_loop();
    int span;
    int body;
    span = $urandom_range(132, 118);
    body = span - 4;
    send_class(CLS_OPEN);
    repeat (body / 4) send_class(CLS_PRINT);
    repeat (body % 4) send_class(CLS_ADD);
    send_class(CLS_CLOSE);
  endtask

  // Nests up to and past the stack depth.
  task automatic deep_nest();
    int n;
    if (sb.wp > 3000) send_finish();
    n = STACK_DEPTH - sb.top + $urandom_range(2);
    repeat (n) send_class(CLS_OPEN);
    repeat ($urandom_range(4)) send_class(CLS_CLOSE);
  endtask

  // Random programs: mostly balanced brackets with random content, some noise.
  task automatic random_program(int n);
    int goal;
    int r;
    goal = items_sent + n;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if ((sb.err_seen && r < 40) || sb.wp > 3900) send_finish();
      else if (r < 3) send_finish();
      else if (r < 13) send_token(1'b0, 8'($urandom_range(255)));
      else if (r < 45) send_class(cls_t'($urandom_range(int'(CLS_LEFT), int'(CLS_ADD))));
      else if (r < 55) send_class(CLS_PRINT);
      else if (r < 68) send_class(sb.top < 12 ? CLS_OPEN : CLS_CLOSE);
      else if (r < 83) begin
        if (sb.top > 0 || $urandom_range(9) == 0) send_class(CLS_CLOSE);
        else send_class(CLS_SUB);
      end
      else if (r < 85) long_loop();
      else if (r == 85) deep_nest();
      else if (r < 88) wait_drain();
      else send_class(CLS_RIGHT);
    end
    wait_drain();
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of every register.
    for (int i = 0; i < 8; i++) cfg_read(3'(i));

    tx_idle_pct = 8;
    rx_idle_pct <= 72;

    // Directed: unmatched close, ignored token, finish after an error.
    send_class(CLS_CLOSE);
    send_token(1'b0, CH_PLUS);
    send_finish();
    // Each non-bracket operation in ASCII and alternate form, plus tokens that decode to nothing.
    send_token(1'b0, CH_PLUS);
    send_token(1'b0, CH_MINUS);
    send_token(1'b0, CH_GT);
    send_token(1'b0, CH_LT);
    send_token(1'b0, CH_DOT);
    send_token(1'b0, ALT_ADD_RST);
    send_token(1'b0, ALT_SUB_RST);
    send_token(1'b0, ALT_RIGHT_RST);
    send_token(1'b0, ALT_LEFT_RST);
    send_token(1'b0, ALT_PRINT_RST);
    send_token(1'b0, 8'h00);
    send_token(1'b0, 8'hFF);
    // Nested brackets, then an unclosed one left at finish.
    send_token(1'b0, CH_OPEN);
    send_token(1'b0, ALT_OPEN_RST);
    send_token(1'b0, CH_PLUS);
    send_token(1'b0, ALT_CLOSE_RST);
    send_token(1'b0, CH_CLOSE);
    send_token(1'b0, CH_OPEN);
    send_token(1'b1, 8'hFF);
    wait_drain();

    // Random programs under several register settings and idling patterns.
    for (int s = 0; s < 5; s++) begin
      if (s < 2) begin
        tx_idle_pct = 8;
        rx_idle_pct <= 72;
      end else if (s < 4) begin
        tx_idle_pct = 72;
        rx_idle_pct <= 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      apply_setting(s);
      burst_req <= burst_req + 1;
      random_program(80);
    end

    wait_drain();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
